FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define XMCR_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define XMCR_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

FILE: src/xmcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xmcr_pkg;

    localparam int PACKET_BYTES_DEF = 128;
    localparam int IDX_W            = 7;
    localparam int CAN_BEATS        = 3;

    localparam logic [7:0] RETRY_RESET = 8'd10;

    localparam logic [7:0] CODE_SOH = 8'h01;
    localparam logic [7:0] CODE_EOT = 8'h04;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_CAN = 8'h18;

    localparam logic [2:0] ACT_BYTE   = 3'd0;
    localparam logic [2:0] ACT_TICK   = 3'd1;
    localparam logic [2:0] ACT_BEGIN  = 3'd2;
    localparam logic [2:0] ACT_END    = 3'd3;
    localparam logic [2:0] ACT_CANCEL = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NAK      = 3'd1;
    localparam logic [2:0] ST_CANCEL   = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    localparam logic REG_RETRY_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BLOCK,
        PH_COMPL,
        PH_DATA,
        PH_SUM
    } phase_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] rx_byte;
        logic [7:0] expected_block;
    } xmcr_in_t;

    typedef struct packed {
        logic             send_valid;
        logic [7:0]       send_byte;
        logic             data_valid;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] data_index;
        logic             done_res;
        logic [2:0]       status;
        logic             last;
    } xmcr_res_t;

    // one token per processed item that has a result; a cancel expands to three beats
    typedef struct packed {
        logic      valid;
        logic      triple;
        xmcr_res_t res;
    } xmcr_tok_t;

endpackage
`default_nettype wire

FILE: src/xmcr_core.sv
`timescale 1ns / 1ps
`default_nettype none
module xmcr_core
    import xmcr_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      take,
    input  wire xmcr_in_t  item,
    input  wire logic [7:0] retry_limit,
    output xmcr_tok_t      tok
);

    localparam int CNT_W = $clog2(PACKET_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PACKET_BYTES - 1);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic             match_reg, match_next;
    logic [7:0]       attempt_reg, attempt_next;
    logic [7:0]       expect_reg, expect_next;

    logic [7:0] limit;
    logic [7:0] attempt_inc;
    logic       miss_end;
    logic       compl_ok;

    assign limit       = (retry_limit == 8'd0) ? 8'd1 : retry_limit;
    assign attempt_inc = attempt_reg + 8'd1;
    assign miss_end    = attempt_inc >= limit;
    assign compl_ok    = match_reg && ((~item.rx_byte) == expect_reg);

    // next state
    always_comb begin
        logic go_idle;
        logic miss;
        go_idle      = 1'b0;
        miss         = 1'b0;
        phase_next   = phase_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        match_next   = match_reg;
        attempt_next = attempt_reg;
        expect_next  = expect_reg;
        if (take) begin
            unique case (item.action) inside
                ACT_BEGIN, ACT_END, ACT_CANCEL: go_idle = 1'b1;
                ACT_TICK: begin
                    if (phase_reg == PH_IDLE) miss = 1'b1;
                    else go_idle = 1'b1;
                end
                ACT_BYTE: begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (item.rx_byte == CODE_SOH) begin
                                expect_next = item.expected_block;
                                count_next  = '0;
                                sum_next    = '0;
                                match_next  = 1'b0;
                                phase_next  = PH_BLOCK;
                            end else if (item.rx_byte == CODE_CAN ||
                                         item.rx_byte == CODE_EOT) begin
                                go_idle = 1'b1;
                            end else begin
                                miss = 1'b1;
                            end
                        end
                        PH_BLOCK: begin
                            match_next = item.rx_byte == expect_reg;
                            phase_next = PH_COMPL;
                        end
                        PH_COMPL: begin
                            if (compl_ok) begin
                                count_next = '0;
                                sum_next   = '0;
                                phase_next = PH_DATA;
                            end else begin
                                go_idle = 1'b1;
                            end
                        end
                        PH_DATA: begin
                            sum_next = sum_reg + item.rx_byte;
                            if (count_reg == CNT_LAST) phase_next = PH_SUM;
                            else count_next = count_reg + 1'b1;
                        end
                        PH_SUM:  go_idle = 1'b1;
                        default: go_idle = 1'b1;
                    endcase
                end
                default: ;
            endcase
        end
        if (miss) begin
            if (miss_end) go_idle = 1'b1;
            else attempt_next = attempt_inc;
        end
        if (go_idle) begin
            phase_next   = PH_IDLE;
            count_next   = '0;
            sum_next     = '0;
            match_next   = 1'b0;
            attempt_next = '0;
        end
    end

    // result token
    always_comb begin
        tok          = '0;
        tok.res.last = 1'b1;
        if (take) begin
            unique case (item.action) inside
                ACT_BEGIN: begin
                    tok.valid             = 1'b1;
                    tok.res.send_valid    = 1'b1;
                    tok.res.send_byte     = CODE_NAK;
                end
                ACT_END: begin
                    tok.valid             = 1'b1;
                    tok.res.send_valid    = 1'b1;
                    tok.res.send_byte     = CODE_ACK;
                end
                ACT_CANCEL: begin
                    tok.valid             = 1'b1;
                    tok.triple            = 1'b1;
                    tok.res.send_valid    = 1'b1;
                    tok.res.send_byte     = CODE_CAN;
                end
                ACT_TICK: begin
                    tok.valid             = 1'b1;
                    tok.res.send_valid    = 1'b1;
                    tok.res.send_byte     = CODE_NAK;
                    if (phase_reg != PH_IDLE || miss_end) begin
                        tok.res.done_res  = 1'b1;
                        tok.res.status    = ST_TIMEOUT;
                    end
                end
                ACT_BYTE: begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (item.rx_byte == CODE_CAN) begin
                                tok.valid            = 1'b1;
                                tok.res.done_res     = 1'b1;
                                tok.res.status       = ST_CANCEL;
                            end else if (item.rx_byte == CODE_EOT) begin
                                tok.valid            = 1'b1;
                                tok.res.done_res     = 1'b1;
                                tok.res.status       = ST_FINISHED;
                            end else if (item.rx_byte != CODE_SOH) begin
                                tok.valid            = 1'b1;
                                tok.res.send_valid   = 1'b1;
                                tok.res.send_byte    = CODE_NAK;
                                if (miss_end) begin
                                    tok.res.done_res = 1'b1;
                                    tok.res.status   = ST_TIMEOUT;
                                end
                            end
                        end
                        PH_BLOCK: ;
                        PH_COMPL: begin
                            if (!compl_ok) begin
                                tok.valid          = 1'b1;
                                tok.res.send_valid = 1'b1;
                                tok.res.send_byte  = CODE_NAK;
                                tok.res.done_res   = 1'b1;
                                tok.res.status     = ST_NAK;
                            end
                        end
                        PH_DATA: begin
                            tok.valid          = 1'b1;
                            tok.res.data_valid = 1'b1;
                            tok.res.data_byte  = item.rx_byte;
                            tok.res.data_index = IDX_W'(count_reg);
                        end
                        PH_SUM: begin
                            tok.valid          = 1'b1;
                            tok.res.send_valid = 1'b1;
                            tok.res.done_res   = 1'b1;
                            if (item.rx_byte == sum_reg) begin
                                tok.res.send_byte = CODE_ACK;
                                tok.res.status    = ST_OK;
                            end else begin
                                tok.res.send_byte = CODE_NAK;
                                tok.res.status    = ST_NAK;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            match_reg   <= 1'b0;
            attempt_reg <= '0;
            expect_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            match_reg   <= match_next;
            attempt_reg <= attempt_next;
            expect_reg  <= expect_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/xmcr_out.sv
`timescale 1ns / 1ps
`default_nettype none
module xmcr_out
    import xmcr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire xmcr_tok_t tok,
    output logic           room,
    output logic           m_valid,
    input  wire logic      m_ready,
    output xmcr_res_t      m_data
);

    localparam int REP_W = $clog2(CAN_BEATS);
    localparam logic [REP_W-1:0] REP_LAST = REP_W'(CAN_BEATS - 1);

    xmcr_tok_t        q_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [REP_W-1:0] rep_reg, rep_next;

    xmcr_tok_t head;
    logic      head_last;
    logic      beat;
    logic      deq;

    assign head      = q_reg[rd_ptr_reg];
    assign head_last = !head.triple || (rep_reg == REP_LAST);
    assign room      = cnt_reg != 2'd2;
    assign m_valid   = cnt_reg != 2'd0;
    assign beat      = m_valid && m_ready;
    assign deq       = beat && head_last;

    always_comb begin
        m_data      = head.res;
        m_data.last = head_last;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        rep_next    = rep_reg;
        if (tok.valid) wr_ptr_next = !wr_ptr_reg;
        if (deq) rd_ptr_next = !rd_ptr_reg;
        case ({tok.valid, deq})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
        // a cancel beat stays at the head until all its copies went out
        if (deq) rep_next = '0;
        else if (beat) rep_next = rep_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (tok.valid) q_reg[wr_ptr_reg] <= tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
            rep_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            rep_reg    <= rep_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/xmodem_checksum_packet_receiver.sv
// path: an accepted beat passes the input stage register and the result queue before it can leave
// throughput: one input beat per cycle while the result queue has room; a cancel holds the result side for three beats
// the rate is set by the two-entry result queue, which keeps one token per item that has a result
// reset: synchronous, active low; clears the receive state, queue and input stage,
// and sets retry_limit to 10
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module xmodem_checksum_packet_receiver
    import xmcr_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire xmcr_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output xmcr_res_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       in_vld_reg, in_vld_next;
    xmcr_in_t   in_reg, in_next;
    logic [7:0] retry_reg, retry_next;

    logic      take;
    logic      room;
    logic      cfg_we;
    xmcr_tok_t tok;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_RETRY_LIMIT);
    assign prdata  = (paddr[2] == REG_RETRY_LIMIT) ? {24'd0, retry_reg} : 32'd0;

    assign take    = in_vld_reg && room;
    assign s_ready = !in_vld_reg || take;

    always_comb begin
        in_vld_next = in_vld_reg;
        in_next     = in_reg;
        retry_next  = retry_reg;
        if (s_ready) in_vld_next = s_valid;
        if (s_valid && s_ready) in_next = s_data;
        if (cfg_we) retry_next = pwdata[7:0];
    end

    always_ff @(posedge aclk) begin
        in_reg <= in_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            retry_reg  <= RETRY_RESET;
        end else begin
            in_vld_reg <= in_vld_next;
            retry_reg  <= retry_next;
        end
    end

    xmcr_core #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .item       (in_reg),
        .retry_limit(retry_reg),
        .tok        (tok)
    );

    xmcr_out u_out (
        .aclk   (aclk),
        .aresetn(aresetn),
        .tok    (tok),
        .room   (room),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    `XMCR_ASSERT(a_index_range, aclk, aresetn, (m_valid && m_data.data_valid) |-> (int'(m_data.data_index) < PACKET_BYTES), "data index beyond packet")
    `XMCR_NEVER(a_send_and_data, aclk, aresetn, m_valid && m_data.send_valid && m_data.data_valid, "reply and payload in one beat")
    `XMCR_ASSERT(a_cancel_run, aclk, aresetn, (m_valid && m_ready && !m_data.last && m_data.send_byte == CODE_CAN) |=> (m_valid && m_data.send_byte == CODE_CAN), "cancel run broken")
    `XMCR_ASSERT(a_ok_acks, aclk, aresetn, (m_valid && m_data.done_res && m_data.status == ST_OK) |-> (m_data.send_valid && m_data.send_byte == CODE_ACK), "ok status without ack")

endmodule
`default_nettype wire

FILE: test/xmodem_checksum_packet_receiver_check.sv
`timescale 1ns / 1ps
module xmodem_checksum_packet_receiver_check
    import xmcr_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  xmcr_in_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  xmcr_res_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          outstanding
);

    localparam logic [2:0] RETRY_ADDR = 3'(4 * REG_RETRY_LIMIT);

    // receiver model state
    phase_t           rx_phase;
    logic [IDX_W-1:0] pkt_count;
    logic [7:0]       pkt_sum;
    logic [7:0]       blk_seen;
    logic             blk_match;
    logic [7:0]       tries;
    logic [7:0]       blk_latched;
    logic [7:0]       retry_lim;

    xmcr_res_t reply_q[$];
    int        err_cnt = 0;

    function automatic xmcr_res_t reply(input logic sv, input logic [7:0] sb,
                                        input logic dv, input logic [7:0] db,
                                        input logic [IDX_W-1:0] di, input logic dn,
                                        input logic [2:0] st, input logic lst);
        xmcr_res_t r;
        r.send_valid = sv;
        r.send_byte  = sb;
        r.data_valid = dv;
        r.data_byte  = db;
        r.data_index = di;
        r.done_res   = dn;
        r.status     = st;
        r.last       = lst;
        return r;
    endfunction

    task automatic go_idle();
        rx_phase  = PH_IDLE;
        pkt_count = '0;
        pkt_sum   = '0;
        blk_match = 1'b0;
        tries     = '0;
    endtask

    task automatic end_wait(input logic send, input logic [7:0] code, input logic [2:0] st);
        go_idle();
        reply_q.push_back(reply(send, send ? code : 8'd0, 1'b0, 8'd0, '0, 1'b1, st, 1'b1));
    endtask

    // stray byte or tick while waiting for a packet start
    task automatic line_miss();
        logic [7:0] lim;
        lim   = (retry_lim == 8'd0) ? 8'd1 : retry_lim;
        tries = tries + 8'd1;
        if (tries >= lim) begin
            go_idle();
            reply_q.push_back(reply(1'b1, CODE_NAK, 1'b0, 8'd0, '0, 1'b1, ST_TIMEOUT, 1'b1));
        end else begin
            reply_q.push_back(reply(1'b1, CODE_NAK, 1'b0, 8'd0, '0, 1'b0, ST_OK, 1'b1));
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic [7:0] e);
        case (rx_phase)
            PH_IDLE: begin
                if (b == CODE_SOH) begin
                    blk_latched = e;
                    pkt_count   = '0;
                    pkt_sum     = '0;
                    blk_match   = 1'b0;
                    rx_phase    = PH_BLOCK;
                end else if (b == CODE_CAN) begin
                    end_wait(1'b0, 8'd0, ST_CANCEL);
                end else if (b == CODE_EOT) begin
                    end_wait(1'b0, 8'd0, ST_FINISHED);
                end else begin
                    line_miss();
                end
            end
            PH_BLOCK: begin
                blk_seen  = b;
                blk_match = (b == blk_latched);
                rx_phase  = PH_COMPL;
            end
            PH_COMPL: begin
                if (blk_match && 8'(~b) == blk_latched) begin
                    pkt_count = '0;
                    pkt_sum   = '0;
                    rx_phase  = PH_DATA;
                end else begin
                    end_wait(1'b1, CODE_NAK, ST_NAK);
                end
            end
            PH_DATA: begin
                reply_q.push_back(reply(1'b0, 8'd0, 1'b1, b, pkt_count, 1'b0, ST_OK, 1'b1));
                pkt_sum = pkt_sum + b;
                if (int'(pkt_count) + 1 >= PACKET_BYTES) begin
                    rx_phase = PH_SUM;
                end else begin
                    pkt_count = pkt_count + 1'b1;
                end
            end
            PH_SUM: begin
                if (b == pkt_sum) begin
                    end_wait(1'b1, CODE_ACK, ST_OK);
                end else begin
                    end_wait(1'b1, CODE_NAK, ST_NAK);
                end
            end
            default: go_idle();
        endcase
    endtask

    task automatic predict_replies(input xmcr_in_t it);
        case (it.action)
            ACT_BEGIN: begin
                go_idle();
                reply_q.push_back(reply(1'b1, CODE_NAK, 1'b0, 8'd0, '0, 1'b0, ST_OK, 1'b1));
            end
            ACT_END: begin
                go_idle();
                reply_q.push_back(reply(1'b1, CODE_ACK, 1'b0, 8'd0, '0, 1'b0, ST_OK, 1'b1));
            end
            ACT_CANCEL: begin
                go_idle();
                for (int k = 0; k < CAN_BEATS; k++) begin
                    reply_q.push_back(reply(1'b1, CODE_CAN, 1'b0, 8'd0, '0, 1'b0, ST_OK,
                                            k == CAN_BEATS - 1));
                end
            end
            ACT_TICK: begin
                if (rx_phase == PH_IDLE) begin
                    line_miss();
                end else begin
                    end_wait(1'b1, CODE_NAK, ST_TIMEOUT);
                end
            end
            ACT_BYTE: take_byte(it.rx_byte, it.expected_block);
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_reply(input xmcr_res_t got);
        xmcr_res_t want;
        if (reply_q.size() == 0) begin
            err_cnt++;
            $display("%0t: result beat expected none, actual %h", $time, got);
        end else begin
            want = reply_q.pop_front();
            check_field("send_valid", want.send_valid, got.send_valid);
            check_field("send_byte", want.send_byte, got.send_byte);
            check_field("data_valid", want.data_valid, got.data_valid);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("data_index", want.data_index, got.data_index);
            check_field("done_res", want.done_res, got.done_res);
            check_field("status", want.status, got.status);
            check_field("last", want.last, got.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            retry_lim   = RETRY_RESET;
            blk_seen    = '0;
            blk_latched = '0;
            go_idle();
            reply_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == RETRY_ADDR) begin
                retry_lim = pwdata[7:0];
            end
            // input beat first so a result that leaves in the same cycle as its input would still find its entry
            if (s_valid && s_ready) begin
                predict_replies(s_data);
            end
            if (m_valid && m_ready) begin
                check_reply(m_data);
            end
        end
        errors      <= err_cnt;
        outstanding <= reply_q.size();
    end

endmodule

FILE: test/xmodem_checksum_packet_receiver_tb.sv
`timescale 1ns / 1ps
module xmodem_checksum_packet_receiver_tb;
    import xmcr_pkg::*;

    localparam int PKT           = PACKET_BYTES_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 12;
    localparam int SHORT_DATA    = 15;

    localparam logic [2:0] RETRY_ADDR    = 3'(4 * REG_RETRY_LIMIT);
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    xmcr_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    xmcr_res_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int outstanding;
    int item_count = 0;
    bit send_gaps  = 1'b1;
    bit sink_gaps  = 1'b1;
    bit hold_go    = 1'b0;

    always #5 aclk = ~aclk;

    xmodem_checksum_packet_receiver #(
        .PACKET_BYTES(PKT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    xmodem_checksum_packet_receiver_check #(
        .PACKET_BYTES(PKT)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin : watchdog
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge aclk);
        $display("xmodem_checksum_packet_receiver_tb: errors");
        $finish;
    end

    // result side: random stalls plus one long hold-off to back up the block
    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            if (hold_go && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge aclk);
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    function automatic xmcr_in_t mk_item(input logic [2:0] act, input logic [7:0] b);
        xmcr_in_t it;
        it.action         = act;
        it.rx_byte        = b;
        it.expected_block = 8'($urandom);
        return it;
    endfunction

    // payload byte, now and then a control code
    function automatic logic [7:0] pick_byte();
        logic [7:0] ctl [5];
        ctl = '{CODE_SOH, CODE_EOT, CODE_ACK, CODE_NAK, CODE_CAN};
        if ($urandom_range(0, 5) == 0) begin
            return ctl[$urandom_range(0, 4)];
        end
        return 8'($urandom);
    endfunction

    task automatic push_item(input xmcr_in_t it);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.action <= ACT_CANCEL) begin
            item_count++;
        end
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        // a trailing beat such as SOH has no result to wait for
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_retry(input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RETRY_ADDR;
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_header(input logic [7:0] exp_blk, input logic [7:0] blk,
                               input logic [7:0] cmp);
        xmcr_in_t it;
        it = mk_item(ACT_BYTE, CODE_SOH);
        it.expected_block = exp_blk;
        push_item(it);
        push_item(mk_item(ACT_BYTE, blk));
        push_item(mk_item(ACT_BYTE, cmp));
    endtask

    task automatic send_data(input int n, output logic [7:0] sum);
        logic [7:0] b;
        sum = 8'd0;
        for (int k = 0; k < n; k++) begin
            b   = pick_byte();
            sum = sum + b;
            push_item(mk_item(ACT_BYTE, b));
        end
    endtask

    // full packet with a good or a corrupted checksum
    task automatic send_packet(input bit good);
        logic [7:0] blk;
        logic [7:0] sum;
        blk = 8'($urandom);
        send_header(blk, blk, ~blk);
        send_data(PKT, sum);
        if (!good) sum = sum + 8'($urandom_range(1, 255));
        push_item(mk_item(ACT_BYTE, sum));
    endtask

    task automatic run_sequence();
        logic [7:0] blk;
        logic [7:0] nz;
        logic [7:0] sum;
        int         kind;
        int         n;
        kind = $urandom_range(3, 9);
        blk  = 8'($urandom);
        nz   = 8'($urandom_range(1, 255));
        case (kind)
            3: begin
                // packet cut short by a tick or a host command
                send_header(blk, blk, ~blk);
                send_data($urandom_range(0, SHORT_DATA), sum);
                push_item(mk_item(3'($urandom_range(ACT_TICK, ACT_CANCEL)), pick_byte()));
            end
            4: begin
                case ($urandom_range(0, 2))
                    0:       send_header(blk, blk ^ nz, ~blk);
                    1:       send_header(blk, blk, ~blk ^ nz);
                    default: send_header(blk, blk ^ nz, ~(blk ^ nz));
                endcase
            end
            5: begin
                push_item(mk_item(ACT_BYTE, CODE_SOH));
                if ($urandom_range(0, 1) == 0) push_item(mk_item(ACT_BYTE, blk));
                push_item(mk_item(3'($urandom_range(ACT_TICK, ACT_CANCEL)), pick_byte()));
            end
            6: begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) push_item(mk_item(ACT_BYTE, pick_byte()));
            end
            7, 8: begin
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        push_item(mk_item(ACT_TICK, 8'($urandom)));
                    end else begin
                        push_item(mk_item(ACT_BYTE, 8'($urandom_range(CODE_NAK, 8'hFF))));
                    end
                end
            end
            default: push_item(mk_item(3'($urandom_range(ACT_BEGIN, ACT_UNUSED_HI)),
                                       8'($urandom)));
        endcase
    endtask

    initial begin : stimulus
        logic [7:0] limits [5];
        int         start;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // commands, unused codes and idle line events at the reset retry limit
        push_item(mk_item(ACT_BEGIN, 8'h00));
        push_item(mk_item(ACT_END, 8'hFF));
        push_item(mk_item(ACT_CANCEL, 8'h00));
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) begin
            push_item(mk_item(3'(a), 8'hFF));
        end
        push_item(mk_item(ACT_BYTE, CODE_EOT));
        push_item(mk_item(ACT_BYTE, CODE_CAN));
        push_item(mk_item(ACT_BYTE, 8'hFF));
        push_item(mk_item(ACT_TICK, 8'h00));

        // control codes as payload, then a tick in mid-packet
        send_header(8'hFF, 8'hFF, 8'h00);
        push_item(mk_item(ACT_BYTE, CODE_SOH));
        push_item(mk_item(ACT_BYTE, CODE_EOT));
        push_item(mk_item(ACT_BYTE, CODE_CAN));
        push_item(mk_item(ACT_BYTE, 8'h00));
        push_item(mk_item(ACT_BYTE, 8'hFF));
        push_item(mk_item(ACT_TICK, 8'h00));

        // bad complement, then bad block number
        send_header(8'h00, 8'h00, 8'h00);
        send_header(8'h55, 8'h54, 8'hAA);

        // last attempt on the first miss, with limit one and zero
        wait_quiet();
        write_retry(8'd1);
        push_item(mk_item(ACT_TICK, 8'h00));
        push_item(mk_item(ACT_BYTE, 8'h80));
        wait_quiet();
        write_retry(8'd0);
        push_item(mk_item(ACT_TICK, 8'h00));

        limits    = '{8'd255, 8'd3, 8'd1, 8'd10, 8'd0};
        limits[4] = 8'($urandom_range(2, 40));
        for (int p = 0; p < 5; p++) begin
            wait_quiet();
            write_retry(limits[p]);
            if (p == 4) begin
                send_gaps = 1'b0;
                sink_gaps = 1'b0;
            end
            // a whole packet while the result side holds off
            if (p == 1) begin
                hold_go = 1'b1;
                send_packet(1'b1);
            end
            if (p == 4) send_packet(1'b0);
            start = item_count;
            while (item_count - start < PHASE_ITEMS) run_sequence();
        end

        wait_quiet();
        if (errors == 0 && outstanding == 0) begin
            $display("xmodem_checksum_packet_receiver_tb: clean");
        end else begin
            $display("xmodem_checksum_packet_receiver_tb: errors");
        end
        $finish;
    end

endmodule
